// ===== rtl/core/fsdc_pkg.sv =====
// fsdc_pkg: constants and the stage record shared by the fuzzy speed and direction controller
// no dependencies; used by fsdc_fuzzify, fsdc_div_cell and the top level
package fsdc_pkg;

  // field widths
  localparam int unsigned DistW  = 16;
  localparam int unsigned AngW   = 16;
  localparam int unsigned SpeedW = 14;
  localparam int unsigned DirW   = 16;

  // divider geometry: quotient magnitude never exceeds 1.0 in Q1.14
  localparam int unsigned QuoW   = 15;
  localparam int unsigned DenW   = 15;
  localparam int unsigned MagW   = 14;
  localparam int unsigned FracW  = 14;
  localparam int unsigned DivSteps = QuoW;

  // distance breakpoints, Q12.4
  localparam logic [DistW-1:0] DistB1 = 16'd320;
  localparam logic [DistW-1:0] DistB3 = 16'd960;

  // speed results at the saturated ends and the ramp offset, Q6.8
  localparam logic [SpeedW-1:0] SpeedSlow = 14'd2560;
  localparam logic [SpeedW-1:0] SpeedFast = 14'd12800;

  // angle breakpoints, degrees times 128, with headroom for the affine terms
  localparam int unsigned AngXW = 19;
  localparam logic signed [AngXW-1:0] AngB1  = 19'sd5760;
  localparam logic signed [AngXW-1:0] AngB2  = 19'sd11520;
  localparam logic signed [AngXW-1:0] AngB3  = 19'sd17280;
  localparam logic signed [AngXW-1:0] AngB4  = 19'sd23040;
  localparam logic signed [AngXW-1:0] AngOne = 19'sd11520;
  localparam logic signed [AngXW-1:0] AngMidNum = 19'sd28800;
  localparam logic signed [AngXW-1:0] AngMidDen = 19'sd51840;
  localparam logic signed [AngXW-1:0] AngTopDen = 19'sd34560;

  // one item as it moves along the divider row
  typedef struct packed {
    logic              valid;
    logic [DenW-1:0]   rem;
    logic [QuoW-1:0]   dvd;
    logic [QuoW-1:0]   quo;
    logic [DenW-1:0]   den;
    logic              neg;
    logic [SpeedW-1:0] speed;
  } cell_t;

endpackage

// ===== rtl/core/fsdc_fuzzify.sv =====
// fsdc_fuzzify: membership evaluation and the first register of the row
// depends on fsdc_pkg; feeds the first fsdc_div_cell
module fsdc_fuzzify (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fsdc_pkg::DistW-1:0]   distance_i,
  input  logic signed [fsdc_pkg::AngW-1:0] heading_angle_i,
  output fsdc_pkg::cell_t              cell_o
);
  import fsdc_pkg::*;

  logic signed [AngXW-1:0] ang;
  logic signed [AngXW-1:0] mag_full;
  logic signed [AngXW-1:0] den_full;
  logic                    neg;
  logic signed [AngXW-1:0] mid_num;
  logic [SpeedW-1:0]       speed;
  logic [MagW-1:0]         mag;
  cell_t                   cell_d;
  logic                    valid_q;
  cell_t                   pay_q;

  // speed: memberships always sum to one, so the weighted mean is a clamped ramp
  always_comb begin
    if (distance_i <= DistB1) begin
      speed = SpeedSlow;
    end else if (distance_i >= DistB3) begin
      speed = SpeedFast;
    end else begin
      speed = {distance_i[9:0], 4'b0000} - SpeedSlow;
    end
  end

  // direction: signed numerator magnitude and membership sum per angle segment
  always_comb begin
    ang      = {{(AngXW-AngW){heading_angle_i[AngW-1]}}, heading_angle_i};
    mid_num  = (ang <<< 1) - AngMidNum;
    mag_full = AngOne;
    den_full = AngOne;
    neg      = 1'b1;
    if (ang <= AngB1) begin
      mag_full = AngOne;
      den_full = AngOne;
      neg      = 1'b1;
    end else if (ang <= AngB2) begin
      mag_full = AngB3 - ang;
      den_full = (ang <<< 1) + ang - AngB1;
      neg      = 1'b1;
    end else if (ang < AngB3) begin
      neg      = mid_num[AngXW-1];
      mag_full = neg ? -mid_num : mid_num;
      den_full = AngMidDen - (ang <<< 1);
    end else if (ang < AngB4) begin
      mag_full = ang - AngB2;
      den_full = AngTopDen - ang;
      neg      = 1'b0;
    end else begin
      mag_full = AngOne;
      den_full = AngOne;
      neg      = 1'b0;
    end
    mag = mag_full[MagW-1:0];
  end

  // dividend is mag scaled by 2^14; the top bits seed the partial remainder
  always_comb begin
    cell_d.valid = start_i;
    cell_d.rem   = {{(DenW-MagW+1){1'b0}}, mag[MagW-1:1]};
    cell_d.dvd   = {mag[0], {FracW{1'b0}}};
    cell_d.quo   = '0;
    cell_d.den   = den_full[DenW-1:0];
    cell_d.neg   = neg;
    cell_d.speed = speed;
  end

  // item valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_d.valid;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    pay_q <= cell_d;
  end

  always_comb begin
    cell_o       = pay_q;
    cell_o.valid = valid_q;
  end

endmodule

// ===== rtl/core/fsdc_div_cell.sv =====
// fsdc_div_cell: one restoring division step, one quotient bit per cell
// depends on fsdc_pkg; chained by the top level
module fsdc_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fsdc_pkg::cell_t cell_i,
  output fsdc_pkg::cell_t cell_o
);
  import fsdc_pkg::*;

  logic [DenW:0] trial;
  logic [DenW:0] diff;
  logic          take;
  cell_t         cell_d;
  logic          valid_q;
  cell_t         pay_q;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial        = {cell_i.rem, cell_i.dvd[QuoW-1]};
    diff         = trial - {1'b0, cell_i.den};
    take         = (trial >= {1'b0, cell_i.den});
    cell_d       = cell_i;
    cell_d.rem   = take ? diff[DenW-1:0] : trial[DenW-1:0];
    cell_d.dvd   = {cell_i.dvd[QuoW-2:0], 1'b0};
    cell_d.quo   = {cell_i.quo[QuoW-2:0], take};
  end

  // item valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    pay_q <= cell_d;
  end

  always_comb begin
    cell_o       = pay_q;
    cell_o.valid = valid_q;
  end

endmodule

// ===== rtl/core/fuzzy_speed_direction_controller_top.sv =====
// fuzzy_speed_direction_controller_top: fuzzy speed and steering controller
// depends on fsdc_pkg, fsdc_fuzzify and fsdc_div_cell
//
// Takes one item per clock cycle (busy_o is always low) and returns its speed and
// direction at the end of the row, marked by done_o for a single cycle; the receiver has
// no way to stall, so results must be taken as they come. The row holds one
// register for membership evaluation, fifteen division cells that each settle one
// quotient bit of the direction, and one output register. Speed is computed at the
// front and rides along the row. Items are independent.
module fuzzy_speed_direction_controller_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [fsdc_pkg::DistW-1:0]          distance_i,
  input  logic signed [fsdc_pkg::AngW-1:0]    heading_angle_i,
  output logic                                done_o,
  output logic [fsdc_pkg::SpeedW-1:0]         speed_o,
  output logic signed [fsdc_pkg::DirW-1:0]    direction_o
);
  import fsdc_pkg::*;

  cell_t             chain [DivSteps+1];
  logic [DirW-1:0]   dir_mag;
  logic [DirW-1:0]   dir_d;
  logic              done_q;
  logic [SpeedW-1:0] speed_q;
  logic [DirW-1:0]   dir_q;

  assign busy_o = 1'b0;

  // membership evaluation
  fsdc_fuzzify u_fuzzify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .distance_i     (distance_i),
    .heading_angle_i(heading_angle_i),
    .cell_o         (chain[0])
  );

  // row of division cells
  for (genvar g = 0; g < DivSteps; g++) begin : g_cell
    fsdc_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cell_i(chain[g]),
      .cell_o(chain[g+1])
    );
  end

  // restore the sign; truncation toward zero falls out of sign-magnitude
  always_comb begin
    dir_mag = {{(DirW-QuoW){1'b0}}, chain[DivSteps].quo};
    dir_d   = chain[DivSteps].neg ? (~dir_mag + 1'b1) : dir_mag;
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[DivSteps].valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    speed_q <= chain[DivSteps].speed;
    dir_q   <= dir_d;
  end

  assign done_o      = done_q;
  assign speed_o     = speed_q;
  assign direction_o = dir_q;

endmodule

// ===== verif/fuzzy_speed_direction_controller_top_tb.sv =====
// fuzzy_speed_direction_controller_top_tb: self-checking bench for the fuzzy speed and steering
// controller; a scoreboard predicts speed and direction per item, depends on fsdc_pkg and the top
`timescale 1ns / 1ps

module fuzzy_speed_direction_controller_top_tb;
  import fsdc_pkg::*;

  // distance breakpoints, Q12.4, and the unit membership
  localparam int DistLo  = 320;
  localparam int DistMid = 640;
  localparam int DistHi  = 960;
  localparam int DistUnit = 320;

  // angle breakpoints, degrees times 128, and the unit membership
  localparam int Ang45  = 5760;
  localparam int Ang90  = 11520;
  localparam int Ang135 = 17280;
  localparam int Ang180 = 23040;
  localparam int AngUnit = 11520;

  // set weights and output scaling
  localparam int WeightSlow = 10;
  localparam int WeightMid  = 30;
  localparam int WeightFast = 50;
  localparam int SpeedScale = 256;
  localparam int DirScale   = 16384;

  localparam int RandItems  = 1830;
  localparam int MaxGap     = 12;
  localparam int DrainCycles = 40;
  localparam int CycleLimit = 200000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [DistW-1:0]         distance_i;
  logic signed [AngW-1:0]   heading_angle_i;
  logic                     done_o;
  logic [SpeedW-1:0]        speed_o;
  logic signed [DirW-1:0]   direction_o;

  int cycle_cnt = 0;

  typedef struct {
    logic [SpeedW-1:0]       speed;
    logic signed [DirW-1:0]  direction;
  } steer_t;

  // predicts speed and direction per accepted item and checks results in order
  class steer_scoreboard;
    steer_t steer_q[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    // weighted average over the three speed sets; memberships always sum to one unit
    function logic [SpeedW-1:0] speed_of(logic [DistW-1:0] dist_val);
      longint d, m_slow, m_mid, m_fast, num;
      d = dist_val;
      if (d <= DistLo) m_slow = DistUnit;
      else if (d <= DistMid) m_slow = DistMid - d;
      else m_slow = 0;
      if (d <= DistLo || d >= DistHi) m_mid = 0;
      else if (d <= DistMid) m_mid = d - DistLo;
      else m_mid = DistHi - d;
      if (d >= DistHi) m_fast = DistUnit;
      else if (d >= DistMid) m_fast = d - DistMid;
      else m_fast = 0;
      num = (WeightSlow * m_slow + WeightMid * m_mid + WeightFast * m_fast) * SpeedScale;
      return SpeedW'(num / (m_slow + m_mid + m_fast));
    endfunction

    // steering average; middle set has twice the slope, quotient truncates toward zero
    function logic signed [DirW-1:0] direction_of(logic signed [AngW-1:0] ang);
      longint a, m_neg, m_ctr, m_pos;
      a = ang;
      if (a <= Ang90) m_neg = AngUnit;
      else if (a >= Ang180) m_neg = 0;
      else m_neg = Ang180 - a;
      if (a <= Ang45 || a >= Ang135) m_ctr = 0;
      else if (a <= Ang90) m_ctr = 2 * (a - Ang45);
      else m_ctr = 2 * (Ang135 - a);
      if (a <= Ang45) m_pos = 0;
      else if (a >= Ang135) m_pos = AngUnit;
      else m_pos = a - Ang45;
      return DirW'(((m_pos - m_neg) * DirScale) / (m_neg + m_ctr + m_pos));
    endfunction

    function void note_item(logic [DistW-1:0] dist_val, logic signed [AngW-1:0] ang);
      steer_t s;
      s.speed = speed_of(dist_val);
      s.direction = direction_of(ang);
      steer_q.push_back(s);
    endfunction

    function void check_result(logic [SpeedW-1:0] speed, logic signed [DirW-1:0] direction);
      steer_t s;
      if (steer_q.size() == 0) begin
        $error("unexpected result: speed %0d, direction %0d", speed, direction);
        errors++;
        return;
      end
      s = steer_q.pop_front();
      if (speed !== s.speed) begin
        $error("speed mismatch: expected %0d, actual %0d", s.speed, speed);
        errors++;
      end
      if (direction !== s.direction) begin
        $error("direction mismatch: expected %0d, actual %0d", s.direction, direction);
        errors++;
      end
    endfunction

    function int pending();
      return steer_q.size();
    endfunction

    function void check_drained();
      if (steer_q.size() != 0) begin
        $error("%0d results never arrived", steer_q.size());
        errors++;
      end
    endfunction
  endclass

  steer_scoreboard sb = new();

  fuzzy_speed_direction_controller_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .distance_i     (distance_i),
    .heading_angle_i(heading_angle_i),
    .done_o         (done_o),
    .speed_o        (speed_o),
    .direction_o    (direction_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("** fuzzy_speed_direction_controller_top: FAILED **");
      $finish;
    end
  end

  // sample accepted items and strobed results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(speed_o, direction_o);
      if (start_i && !busy_o) sb.note_item(distance_i, heading_angle_i);
    end
  end

  // hold start low with junk on the fields for the given gap, then present one item
  task automatic drive_item(input logic [DistW-1:0] dist_val,
                            input logic signed [AngW-1:0] ang,
                            input int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i = 1'b0;
      distance_i = DistW'($urandom);
      heading_angle_i = AngW'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    distance_i = dist_val;
    heading_angle_i = ang;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic logic [DistW-1:0] draw_distance();
    int unsigned pick;
    int dist_bp[3];
    pick = $urandom_range(0, 99);
    dist_bp = '{DistLo, DistMid, DistHi};
    if (pick < 60) return DistW'($urandom_range(0, 1100));
    if (pick < 75) return DistW'(dist_bp[$urandom_range(0, 2)] + $urandom_range(0, 8) - 4);
    return DistW'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [AngW-1:0] draw_angle();
    int unsigned pick;
    int ang_bp[4];
    pick = $urandom_range(0, 99);
    ang_bp = '{Ang45, Ang90, Ang135, Ang180};
    if (pick < 55) return AngW'(int'($urandom_range(0, 2 * Ang180)) - Ang180);
    if (pick < 80) return AngW'($urandom_range(5000, 18500));
    if (pick < 92) return AngW'(ang_bp[$urandom_range(0, 3)] + $urandom_range(0, 8) - 4);
    return AngW'($urandom_range(0, 65535));
  endfunction

  // stimulus
  initial begin
    logic [DistW-1:0]       dir_dist[20];
    logic signed [AngW-1:0] dir_ang[20];
    bit burst;

    rst_ni = 1'b0;
    start_i = 1'b0;
    distance_i = '0;
    heading_angle_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: set edges, saturated ends and field extremes
    dir_dist = '{16'd0, 16'd1, 16'd319, 16'd320, 16'd321, 16'd480, 16'd639, 16'd640,
                 16'd641, 16'd800, 16'd959, 16'd960, 16'd961, 16'd1000, 16'd65535,
                 16'd32768, 16'd12345, 16'd700, 16'd400, 16'd900};
    dir_ang = '{-16'sd32768, -16'sd23040, -16'sd1, 16'sd0, 16'sd5760, 16'sd5761, 16'sd5762,
                16'sd8000, 16'sd11519, 16'sd11520, 16'sd11521, 16'sd15000, 16'sd17279,
                16'sd17280, 16'sd17281, 16'sd23039, 16'sd23040, 16'sd23041, 16'sd32767,
                16'sd100};
    foreach (dir_dist[i]) drive_item(dir_dist[i], dir_ang[i], (i % 3 == 0) ? 2 : 0);

    // random items, with back-to-back bursts mixed in
    burst = 1'b0;
    for (int i = 0; i < RandItems; i++) begin
      if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      drive_item(draw_distance(), draw_angle(), draw_gap(burst));
    end
    @(negedge clk_i);
    start_i = 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.check_drained();

    if (sb.errors == 0) begin
      $display("** fuzzy_speed_direction_controller_top: PASSED **");
    end else begin
      $display("** fuzzy_speed_direction_controller_top: FAILED **");
    end
    $finish;
  end

endmodule
